// ===== design/pfg_pkg.sv =====
package pfg_pkg;

  localparam int MAX_CHANNELS        = 12;
  localparam int CHANNEL_RESET_VALUE = 1500;

  // Field widths of the channels and the configuration registers.
  localparam int CHANNEL_W   = 4;
  localparam int WIDTH_W     = 16;
  localparam int PULSE_LEN_W = 12;
  localparam int FRAME_LEN_W = 16;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int TICKS_W     = 16;
  localparam int SUM_W       = 20;

  // Width store addressing; the slot index must also hold MAX_CHANNELS itself.
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W   = $clog2(MAX_CHANNELS + 1);

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd50;

  localparam logic [PULSE_LEN_W-1:0] PULSE_LEN_RESET     = 12'd300;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET     = 16'd22500;
  localparam logic                   ACTIVE_HIGH_RESET   = 1'b1;
  localparam logic [COUNT_W-1:0]     CHANNEL_COUNT_RESET = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LEN     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LEN     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HIGH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

  // Input item modes.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] addr;
    logic [WIDTH_W-1:0]  data;
  } store_wr_t;

  typedef struct packed {
    logic               valid;
    logic [WIDTH_W-1:0] data;
  } store_rd_t;

  typedef struct packed {
    logic ppm_level;
    logic frame_start;
    logic overrun;
  } result_t;

endpackage

// ===== design/pfg_if.sv =====
interface pfg_item_if import pfg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [CHANNEL_W-1:0] channel;
  logic [WIDTH_W-1:0]   width_us;

  modport source(output valid, mode, channel, width_us, input ready);
  modport sink(input valid, mode, channel, width_us, output ready);
endinterface

interface pfg_result_if ();
  logic valid;
  logic ready;
  logic ppm_level;
  logic frame_start;
  logic overrun;

  modport source(output valid, ppm_level, frame_start, overrun, input ready);
  modport sink(input valid, ppm_level, frame_start, overrun, output ready);
endinterface

interface pfg_cfg_if import pfg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/pfg_width_store.sv =====
module pfg_width_store import pfg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output store_rd_t         rd
);

  logic [WIDTH_W-1:0]      mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] written;
  logic                    rd_in_range;
  logic                    fwd;

  assign rd_in_range = rd_addr < SLOT_W'(MAX_CHANNELS);
  assign fwd         = wr.en && (SLOT_W'(wr.addr) == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // A write to the entry being read in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd.valid <= 1'b0;
    end else if (fwd) begin
      rd.valid <= 1'b1;
    end else if (rd_in_range) begin
      rd.valid <= written[rd_addr[CH_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fwd) begin
      rd.data <= wr.data;
    end else if (rd_in_range) begin
      rd.data <= mem[rd_addr[CH_IDX_W-1:0]];
    end
  end

  a_fwd_data: assert property (@(posedge clk) disable iff (rst)
    fwd |=> rd.valid && rd.data == $past(wr.data))
    else $error("width store forwarding lost a write");

  a_fwd_hold: assert property (@(posedge clk) disable iff (rst)
    !wr.en && !rd_in_range |=> $stable(rd.data) && $stable(rd.valid))
    else $error("width store read data changed without a valid address");

endmodule

// ===== design/ppm_frame_generator_core.sv =====
// Channel   Direction  Handshake      Payload
// item      in         valid/ready    mode, channel, width_us
// result    out        valid/ready    ppm_level, frame_start, overrun
// cfg       in         valid/ready    index, data
//
// One item per clock while the skid entry is empty: each accepted item yields one result transaction.
// The width of the current slot is read from the registered store output, addressed by
// the next slot index, so the end of a pulse never waits on the memory.
// Reset (rst, synchronous) restores the registers and marks every stored width as the
// default, with no clearing sweep; neither item nor cfg is ready while rst is high. An output register
// and one skid entry keep item ready for one more transaction while a result is held.
module ppm_frame_generator_core import pfg_pkg::*; (
  input logic           clk,
  input logic           rst,
  pfg_item_if.sink      item,
  pfg_result_if.source  result,
  pfg_cfg_if.sink       cfg
);

  logic [PULSE_LEN_W-1:0] pulse_len;
  logic [FRAME_LEN_W-1:0] frame_len;
  logic                   active_high;
  logic [COUNT_W-1:0]     channel_count;

  logic               in_pulse, in_pulse_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [SLOT_W-1:0]  slot_index, slot_index_next;
  logic [SUM_W-1:0]   frame_sum, frame_sum_next;

  store_wr_t store_wr;
  store_rd_t store_rd;

  logic               in_fire;
  logic [SLOT_W-1:0]  count;
  logic [WIDTH_W-1:0] slot_width;
  logic [SUM_W:0]     total;
  result_t            res_new;

  result_t out_q, skid_q;
  logic    out_valid, skid_valid;
  logic    out_free;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_len     <= PULSE_LEN_RESET;
      frame_len     <= FRAME_LEN_RESET;
      active_high   <= ACTIVE_HIGH_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PULSE_LEN:     pulse_len     <= cfg.data[PULSE_LEN_W-1:0];
        CFG_FRAME_LEN:     frame_len     <= cfg.data[FRAME_LEN_W-1:0];
        CFG_ACTIVE_HIGH:   active_high   <= cfg.data[0];
        CFG_CHANNEL_COUNT: channel_count <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.ready = !skid_valid && !rst;
  assign in_fire    = item.valid && item.ready;

  assign store_wr.en   = in_fire && (item.mode == MODE_WRITE)
                         && (int'(item.channel) < MAX_CHANNELS);
  assign store_wr.addr = CH_IDX_W'(item.channel);
  assign store_wr.data = item.width_us;

  pfg_width_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (store_wr),
    .rd_addr (slot_index_next),
    .rd      (store_rd)
  );

  // Entries never written hold the default width.
  assign slot_width = store_rd.valid ? store_rd.data : WIDTH_W'(CHANNEL_RESET_VALUE);
  assign count      = (int'(channel_count) > MAX_CHANNELS) ? SLOT_W'(MAX_CHANNELS)
                                                           : SLOT_W'(channel_count);
  assign total      = (SUM_W + 1)'(frame_sum) + (SUM_W + 1)'(pulse_len);

  always_comb begin
    in_pulse_next       = in_pulse;
    ticks_left_next     = ticks_left;
    slot_index_next     = slot_index;
    frame_sum_next      = frame_sum;
    res_new.frame_start = 1'b0;
    res_new.overrun     = 1'b0;
    if (in_fire && item.mode == MODE_TICK) begin
      if (ticks_left > TICKS_W'(1)) begin
        ticks_left_next = ticks_left - TICKS_W'(1);
      end else if (!in_pulse) begin
        in_pulse_next       = 1'b1;
        ticks_left_next     = TICKS_W'(pulse_len);
        res_new.frame_start = (slot_index == '0);
      end else begin
        in_pulse_next = 1'b0;
        if (slot_index >= count) begin
          // Sync gap pads the frame; it collapses to zero when the channels overran.
          if (total > (SUM_W + 1)'(frame_len)) begin
            ticks_left_next = '0;
            res_new.overrun = 1'b1;
          end else begin
            ticks_left_next = frame_len - total[TICKS_W-1:0];
          end
          slot_index_next = '0;
          frame_sum_next  = '0;
        end else begin
          if (slot_width > WIDTH_W'(pulse_len)) begin
            ticks_left_next = slot_width - WIDTH_W'(pulse_len);
          end else begin
            ticks_left_next = '0;
          end
          frame_sum_next  = frame_sum + SUM_W'(slot_width);
          slot_index_next = slot_index + SLOT_W'(1);
        end
      end
    end
    res_new.ppm_level = in_pulse_next ? active_high : !active_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse   <= 1'b0;
      ticks_left <= TICKS_RESET;
      slot_index <= '0;
      frame_sum  <= '0;
    end else begin
      in_pulse   <= in_pulse_next;
      ticks_left <= ticks_left_next;
      slot_index <= slot_index_next;
      frame_sum  <= frame_sum_next;
    end
  end

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= skid_valid && in_fire;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
        if (in_fire) begin
          skid_q <= res_new;
        end
      end else if (in_fire) begin
        out_q <= res_new;
      end
    end else if (in_fire) begin
      skid_q <= res_new;
    end
  end

  assign result.valid       = out_valid;
  assign result.ppm_level   = out_q.ppm_level;
  assign result.frame_start = out_q.frame_start;
  assign result.overrun     = out_q.overrun;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the output register is empty");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_index <= SLOT_W'(MAX_CHANNELS))
    else $error("slot index ran past the channel store");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    in_fire && item.mode == MODE_TICK && ticks_left > TICKS_W'(1)
    |=> ticks_left == $past(ticks_left) - TICKS_W'(1) && $stable(in_pulse))
    else $error("tick did not count down the current segment");

  a_overrun_ends_frame: assert property (@(posedge clk) disable iff (rst)
    in_fire && res_new.overrun |=> slot_index == '0 && frame_sum == '0 && !in_pulse)
    else $error("overrun flagged outside the end of a frame");

endmodule
